>>> rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/fcpu_pkg.sv
// Shared constants, types and the arctangent table of the fly camera pose unit.
// No dependencies.
`default_nettype none
package fcpu_pkg;

    localparam int ZW = 26;              // angle width, signed Q9.16 degrees
    localparam int XW = 34;              // CORDIC x/y width, Q30
    localparam int CORDIC_STEPS = 20;

    localparam logic signed [ZW-1:0] DEG_FULL    = 26'sd23592960;
    localparam logic signed [ZW-1:0] DEG_HALF    = 26'sd11796480;
    localparam logic signed [ZW-1:0] DEG_QUARTER = 26'sd5898240;
    localparam logic signed [ZW-1:0] PITCH_LIMIT = 26'sd5832704;
    localparam logic [24:0]          YAW_RESET   = 25'd17694720;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032875;

    localparam logic [23:0] SPEED_RESET = 24'd163840;
    localparam logic [15:0] SENS_RESET  = 16'd6554;

    localparam logic FUNC_LOOK = 1'b0;
    localparam logic FUNC_MOVE = 1'b1;

    localparam logic CFG_MOVE_SPEED = 1'b0;
    localparam logic CFG_LOOK_SENS  = 1'b1;

    typedef struct packed {
        logic                 start;
        logic signed [ZW-1:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    // atan(2^-i) in Q16 degrees
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/fcpu_if.sv
// Channel interfaces of the fly camera pose unit: input items, results, register writes.
// No dependencies.
`default_nettype none
interface fcpu_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [15:0] look_dx;
    logic signed [15:0] look_dy;
    logic               move_fwd;
    logic               move_back;
    logic               move_left;
    logic               move_right;
    logic               move_rise;
    logic               move_sink;
    logic        [15:0] frame_time;
    modport source (output valid, func, look_dx, look_dy, move_fwd, move_back, move_left,
                    move_right, move_rise, move_sink, frame_time, input ready);
    modport sink (input valid, func, look_dx, look_dy, move_fwd, move_back, move_left,
                  move_right, move_rise, move_sink, frame_time, output ready);
endinterface

interface fcpu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                    up_x, up_y, up_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  up_x, up_y, up_z, output ready);
endinterface

interface fcpu_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/fcpu_cordic.sv
// Iterative rotation-mode CORDIC in degrees: one micro-rotation per cycle.
// Depends on fcpu_pkg.
`default_nettype none
module fcpu_cordic
    import fcpu_pkg::*;
#(
    parameter int TFB = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cordic_req         i_req,
    output t_cordic_stat        o_stat,
    output logic signed [TFB+1:0] o_sin,
    output logic signed [TFB+1:0] o_cos
);

    localparam int TW  = TFB + 2;
    localparam int SHR = 30 - TFB;
    localparam logic signed [XW-1:0] RND = XW'(64'sd1 <<< (SHR - 1));
    localparam logic signed [XW-1:0] ONE = XW'(64'sd1 <<< TFB);

    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_neg, r_run, r_fin, r_done;
    logic [4:0]           r_i;
    logic signed [TW-1:0] r_sin, r_cos;

    logic signed [ZW-1:0] za;
    logic                 zneg;
    logic signed [XW-1:0] sx, sy;
    logic signed [ZW-1:0] at;

    function automatic logic signed [TW-1:0] fin_round(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v + RND) >>> SHR;
        if (t > ONE) t = ONE;
        else if (t < -ONE) t = -ONE;
        return TW'(t);
    endfunction

    // fold the angle into [-90, 90] degrees
    always_comb begin
        za   = i_req.angle;
        zneg = 1'b0;
        if (za > DEG_HALF) za = za - DEG_FULL;
        if (za > DEG_QUARTER) begin
            za   = za - DEG_HALF;
            zneg = 1'b1;
        end else if (za < -DEG_QUARTER) begin
            za   = za + DEG_HALF;
            zneg = 1'b1;
        end
    end

    assign sx = r_x >>> r_i;
    assign sy = r_y >>> r_i;
    assign at = $signed(ZW'(atan_q16(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_i == 5'(CORDIC_STEPS - 1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= za;
            r_neg <= zneg;
            r_i   <= '0;
        end else if (r_run) begin
            if (r_z >= 0) begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + at;
            end
            r_i <= r_i + 5'd1;
        end
        if (r_fin) begin
            r_cos <= fin_round(r_neg ? -r_x : r_x);
            r_sin <= fin_round(r_neg ? -r_y : r_y);
        end
    end

    assign o_stat.busy = r_run | r_fin;
    assign o_stat.done = r_done;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

>>> rtl/fly_camera_pose_update_unit.sv
// Top level of the fly camera pose unit: sequencer, shared multiplier and pose state.
// Depends on fcpu_pkg, fcpu_if, fcpu_cordic and assert_macros.svh.
//
//  channel  dir  handshake            payload
//  i_in     in   valid/ready          func, look offsets, move flags, frame_time
//  o_out    out  valid/ready          position Q16.16, front and up vectors Q1.14
//  i_cfg    in   valid/ready (ready=1) index (0 speed, 1 sensitivity), data
//
// Each CORDIC pass runs start, 20 micro-rotations, rounding and done. Besides the CORDIC
// passes, an item uses the shared multiplier, the 9-step yaw reduction (look), the 6 flag
// steps (move) and the 5 vector steps. The input reopens as the result is loaded; a result
// that is not taken holds the unit in its last step.
// Reset is synchronous; it restores the pose and both registers, no clearing pass.
// One item is in work at a time; a new item is taken while a result waits in o_out.
`default_nettype none
`include "assert_macros.svh"
module fly_camera_pose_update_unit
    import fcpu_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fcpu_in_if.sink           i_in,
    fcpu_out_if.source        o_out,
    fcpu_cfg_if.sink          i_cfg
);

    localparam int TFB = TRIG_FRAC_BITS;
    localparam int TW  = TFB + 2;            // trig value width, range +-2^TFB
    localparam int MA  = 25;
    localparam int MB  = (TW > 17) ? TW : 17;
    localparam int PW  = MA + MB;
    localparam int VW  = 26;                 // rounded velocity times trig
    localparam logic signed [PW-1:0] RNDT = PW'(64'sd1 <<< (TFB - 1));
    localparam int Q_SH = (TFB >= 14) ? TFB - 14 : 0;
    localparam int Q_LS = (TFB < 14) ? 14 - TFB : 0;
    localparam logic signed [39:0] Q_RND = (Q_SH > 0) ? 40'(64'sd1 <<< (Q_SH - 1)) : 40'sd0;

    // sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LX   = 5'd1;
    localparam logic [4:0] S_LY   = 5'd2;
    localparam logic [4:0] S_LP   = 5'd3;
    localparam logic [4:0] S_WRAP = 5'd4;
    localparam logic [4:0] S_MV   = 5'd5;
    localparam logic [4:0] S_VEL  = 5'd6;
    localparam logic [4:0] S_YAWS = 5'd7;
    localparam logic [4:0] S_YAWW = 5'd8;
    localparam logic [4:0] S_VX   = 5'd9;
    localparam logic [4:0] S_VZ   = 5'd10;
    localparam logic [4:0] S_VR   = 5'd11;
    localparam logic [4:0] S_FLAG = 5'd12;
    localparam logic [4:0] S_PITS = 5'd13;
    localparam logic [4:0] S_PITW = 5'd14;
    localparam logic [4:0] S_VEC  = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    logic [4:0] r_state, n_state;

    // configuration and pose state
    logic [23:0]          r_speed;
    logic [15:0]          r_sens;
    logic [24:0]          r_yaw;
    logic signed [23:0]   r_pitch;
    logic signed [31:0]   r_pos [3];

    // captured item
    logic                 r_func;
    logic signed [15:0]   r_dx, r_dy;
    logic [5:0]           r_flags;
    logic [15:0]          r_ft;

    // working registers
    logic signed [PW-1:0] r_prod;
    logic signed [33:0]   r_ysum;
    logic [3:0]           r_k;
    logic [2:0]           r_j;
    logic [23:0]          r_vel;
    logic signed [VW-1:0] r_fx, r_fz;
    logic signed [TW-1:0] r_sy, r_cy, r_sp, r_cp;
    logic signed [15:0]   r_vec [6];

    // result register
    logic                 r_ovalid;
    logic signed [31:0]   r_opos [3];
    logic signed [15:0]   r_ovec [6];

    logic signed [MA-1:0] n_ma;
    logic signed [MB-1:0] n_mb;
    logic signed [PW-1:0] prod_rnd;
    logic signed [TW-1:0] prod_t;
    logic signed [33:0]   psum, dk, d_x, d_y, d_z;
    logic                 f_on, out_free;

    t_cordic_req          cq;
    t_cordic_stat         cs;
    logic signed [TW-1:0] c_sin, c_cos;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
        if (s > 34'sd2147483647) return 32'sh7fffffff;
        if (s < -34'sd2147483648) return 32'sh80000000;
        return 32'(s);
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [TW-1:0] v);
        logic signed [39:0] t;
        t = ((40'(v) + Q_RND) >>> Q_SH) <<< Q_LS;
        if (t > 40'sd16384) t = 40'sd16384;
        else if (t < -40'sd16384) t = -40'sd16384;
        return 16'(t);
    endfunction

    fcpu_cordic #(.TFB(TFB)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cq),
        .o_stat  (cs),
        .o_sin   (c_sin),
        .o_cos   (c_cos)
    );

    assign cq.start = (r_state == S_YAWS) || (r_state == S_PITS);
    assign cq.angle = (r_state == S_YAWS) ? $signed(ZW'(r_yaw)) : ZW'(r_pitch);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_ovalid || o_out.ready;

    // shared multiplier operand select
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            S_LX: begin
                n_ma = MA'(r_dx);
                n_mb = $signed(MB'(r_sens));
            end
            S_LY: begin
                n_ma = MA'(r_dy);
                n_mb = $signed(MB'(r_sens));
            end
            S_MV: begin
                n_ma = $signed(MA'(r_speed));
                n_mb = $signed(MB'(r_ft));
            end
            S_VX: begin
                n_ma = $signed(MA'(r_vel));
                n_mb = MB'(r_cy);
            end
            S_VZ: begin
                n_ma = $signed(MA'(r_vel));
                n_mb = MB'(r_sy);
            end
            S_VEC: begin
                n_ma = (r_j == 3'd0 || r_j == 3'd2) ? MA'(r_cy) : MA'(r_sy);
                n_mb = (r_j == 3'd0 || r_j == 3'd1) ? MB'(r_cp) : MB'(r_sp);
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    assign prod_rnd = (r_prod + RNDT) >>> TFB;
    assign prod_t   = TW'(prod_rnd);
    assign psum     = 34'(r_pitch) + 34'(r_prod);
    assign dk       = $signed(34'(DEG_FULL) <<< r_k);
    assign f_on     = r_flags[r_j];

    // position deltas for the current flag: fwd, back, left, right, rise, sink
    always_comb begin
        d_x = '0;
        d_y = '0;
        d_z = '0;
        unique case (r_j)
            3'd0: begin
                d_x = 34'(r_fx);
                d_z = 34'(r_fz);
            end
            3'd1: begin
                d_x = -34'(r_fx);
                d_z = -34'(r_fz);
            end
            3'd2: begin
                d_x = 34'(r_fz);
                d_z = -34'(r_fx);
            end
            3'd3: begin
                d_x = -34'(r_fz);
                d_z = 34'(r_fx);
            end
            3'd4: d_y = $signed(34'(r_vel));
            3'd5: d_y = -$signed(34'(r_vel));
            default: begin
                d_x = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = (i_in.func == FUNC_MOVE) ? S_MV : S_LX;
            S_LX:   n_state = S_LY;
            S_LY:   n_state = S_LP;
            S_LP:   n_state = S_WRAP;
            S_WRAP: if (r_k == 4'd0) n_state = S_YAWS;
            S_MV:   n_state = S_VEL;
            S_VEL:  n_state = S_YAWS;
            S_YAWS: n_state = S_YAWW;
            S_YAWW: if (cs.done) n_state = (r_func == FUNC_MOVE) ? S_VX : S_PITS;
            S_VX:   n_state = S_VZ;
            S_VZ:   n_state = S_VR;
            S_VR:   n_state = S_FLAG;
            S_FLAG: if (r_j == 3'd5) n_state = S_PITS;
            S_PITS: n_state = S_PITW;
            S_PITW: if (cs.done) n_state = S_VEC;
            S_VEC:  if (r_j == 3'd4) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_speed  <= SPEED_RESET;
            r_sens   <= SENS_RESET;
            r_yaw    <= YAW_RESET;
            r_pitch  <= '0;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
        end else begin
            r_state <= n_state;

            // drop zero writes, keep the old value
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_MOVE_SPEED: if (i_cfg.data != '0) r_speed <= i_cfg.data;
                    CFG_LOOK_SENS:  if (i_cfg.data[15:0] != '0) r_sens <= i_cfg.data[15:0];
                    default: ;
                endcase
            end

            if (r_state == S_LP) begin
                if (psum > 34'(PITCH_LIMIT)) r_pitch <= 24'(PITCH_LIMIT);
                else if (psum < -34'(PITCH_LIMIT)) r_pitch <= -24'(PITCH_LIMIT);
                else r_pitch <= 24'(psum);
            end

            if (r_state == S_WRAP && r_k == 4'd0) begin
                if (r_ysum >= dk) r_yaw <= 25'(r_ysum - dk);
                else r_yaw <= 25'(r_ysum);
            end

            if (r_state == S_FLAG && f_on) begin
                r_pos[0] <= sat32(34'(r_pos[0]) + d_x);
                r_pos[1] <= sat32(34'(r_pos[1]) + d_y);
                r_pos[2] <= sat32(34'(r_pos[2]) + d_z);
            end

            // hold the result until its transfer, then load the next one
            if (r_state == S_DONE && out_free) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(n_ma * n_mb);

        if (r_state == S_IDLE && i_in.valid) begin
            r_func  <= i_in.func;
            r_dx    <= i_in.look_dx;
            r_dy    <= i_in.look_dy;
            r_ft    <= i_in.frame_time;
            r_flags <= {i_in.move_sink, i_in.move_rise, i_in.move_right,
                        i_in.move_left, i_in.move_back, i_in.move_fwd};
        end

        unique case (r_state)
            S_LY: r_ysum <= $signed(34'(r_yaw)) + 34'(r_prod);
            S_LP: r_k <= 4'd8;
            S_WRAP: begin
                // wrap negatives first, then subtract 360 degrees times 2^k
                if (r_k == 4'd8) begin
                    if (r_ysum < 0) r_ysum <= r_ysum + dk;
                end else if (r_ysum >= dk) begin
                    r_ysum <= r_ysum - dk;
                end
                r_k <= r_k - 4'd1;
            end
            S_VEL: r_vel <= r_prod[39:16];
            S_YAWW: if (cs.done) begin
                r_sy <= c_sin;
                r_cy <= c_cos;
            end
            S_VZ: r_fx <= VW'(prod_rnd);
            S_VR: begin
                r_fz <= VW'(prod_rnd);
                r_j  <= 3'd0;
            end
            S_FLAG: r_j <= r_j + 3'd1;
            S_PITW: if (cs.done) begin
                r_sp <= c_sin;
                r_cp <= c_cos;
                r_j  <= 3'd0;
            end
            S_VEC: begin
                // consume the product issued one step earlier
                unique case (r_j)
                    3'd0: begin
                        r_vec[1] <= to_q14(r_sp);
                        r_vec[4] <= to_q14(r_cp);
                    end
                    3'd1: r_vec[0] <= to_q14(prod_t);
                    3'd2: r_vec[2] <= to_q14(prod_t);
                    3'd3: r_vec[3] <= to_q14(-prod_t);
                    3'd4: r_vec[5] <= to_q14(-prod_t);
                    default: ;
                endcase
                r_j <= r_j + 3'd1;
            end
            S_DONE: if (out_free) begin
                r_opos[0] <= r_pos[0];
                r_opos[1] <= r_pos[1];
                r_opos[2] <= r_pos[2];
                for (int i = 0; i < 6; i++) r_ovec[i] <= r_vec[i];
            end
            default: ;
        endcase
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.pos_x   = r_opos[0];
    assign o_out.pos_y   = r_opos[1];
    assign o_out.pos_z   = r_opos[2];
    assign o_out.front_x = r_ovec[0];
    assign o_out.front_y = r_ovec[1];
    assign o_out.front_z = r_ovec[2];
    assign o_out.up_x    = r_ovec[3];
    assign o_out.up_y    = r_ovec[4];
    assign o_out.up_z    = r_ovec[5];

    `ASSERT_SAME(a_yaw_range, i_clk, i_rst_n, 1'b1, $signed({1'b0, r_yaw}) < DEG_FULL)
    `ASSERT_SAME(a_pitch_range, i_clk, i_rst_n, 1'b1, (26'(r_pitch) <= PITCH_LIMIT) && (26'(r_pitch) >= -PITCH_LIMIT))
    `ASSERT_SAME(a_cordic_wait, i_clk, i_rst_n, cs.done, (r_state == S_YAWW) || (r_state == S_PITW))
    `ASSERT_SAME(a_cordic_free, i_clk, i_rst_n, cq.start, !cs.busy)
    `ASSERT_NEXT(a_item_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)

endmodule
`default_nettype wire

>>> tb/sv/fly_camera_pose_update_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for fly_camera_pose_update_unit: directed plan, then random look/move traffic.
// Depends on fcpu_pkg, fcpu_if and the RTL of the unit.
`default_nettype none
module fly_camera_pose_update_unit_test
    import fcpu_pkg::*;
;

    localparam longint DEG_ONE  = 64'sd65536;
    localparam longint FULL     = longint'(DEG_FULL);
    localparam longint HALF     = longint'(DEG_HALF);
    localparam longint QUARTER  = longint'(DEG_QUARTER);
    localparam longint PITCH_LIM = longint'(PITCH_LIMIT);
    localparam int     TRIG_BITS = 14;
    localparam int     CYCLE_LIMIT = 1500000;
    localparam int     SETTLE_CYCLES = 80;    // longer than one move item in work
    localparam int     HOLD_CYCLES = 500;

    // move flag bits, in the order the unit applies them
    localparam logic [5:0] FL_FWD   = 6'b100000;
    localparam logic [5:0] FL_BACK  = 6'b010000;
    localparam logic [5:0] FL_LEFT  = 6'b001000;
    localparam logic [5:0] FL_RIGHT = 6'b000100;
    localparam logic [5:0] FL_RISE  = 6'b000010;
    localparam logic [5:0] FL_SINK  = 6'b000001;
    localparam logic [5:0] FL_NONE  = 6'b000000;
    localparam logic [5:0] FL_ALL   = 6'b111111;

    // random traffic flavors
    localparam int MIX_ANY   = 0;
    localparam int MIX_CLIMB = 1;
    localparam int MIX_DIVE  = 2;

    typedef struct {
        logic               func;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic        [5:0]  flags;
        logic        [15:0] ft;
    } t_cmd;

    typedef struct {
        logic signed [31:0] pos_x, pos_y, pos_z;
        logic signed [15:0] front_x, front_y, front_z;
        logic signed [15:0] up_x, up_y, up_z;
    } t_pose;

    // directed plan row; typed rows also carry the known position
    typedef struct {
        logic        func;
        int          dx, dy;
        logic [5:0]  flags;
        int          ft;
        bit          typed;
        int          px, py, pz;
    } t_plan_row;

    localparam longint ATAN_DEG[CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    fcpu_in_if  in_ch();
    fcpu_out_if out_ch();
    fcpu_cfg_if cfg_ch();

    fly_camera_pose_update_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // camera state as the bench expects it
    longint     cam_yaw, cam_pitch;
    longint     cam_pos[3];
    logic [23:0] cam_speed;
    logic [15:0] cam_sens;

    t_pose  pose_q[$];
    int     fail_cnt = 0;
    int     n_items = 0;
    int     n_checked = 0;
    int     n_cfg = 0;
    int     cycle_cnt = 0;
    bit     tx_gaps_on = 1'b1;
    bit     rx_stalls_on = 1'b1;
    int     hold_asked = 0;
    int     hold_served = 0;

    t_plan_row plan[] = '{
        // fresh after reset: zero frame time leaves the origin
        '{FUNC_MOVE, 0, 0, FL_ALL, 0, 1, 0, 0, 0},
        '{FUNC_LOOK, 0, 0, FL_NONE, 0, 1, 0, 0, 0},
        // pitch runs into both clamps, yaw wraps
        '{FUNC_LOOK, 32767, 32767, FL_NONE, 0, 1, 0, 0, 0},
        '{FUNC_LOOK, -32768, -32768, FL_NONE, 0, 1, 0, 0, 0},
        '{FUNC_LOOK, 1, 0, FL_NONE, 0, 1, 0, 0, 0},
        // look ignores move flags and frame time
        '{FUNC_LOOK, -1, 900, FL_ALL, 65535, 1, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_FWD, 65535, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_BACK, 65535, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_LEFT, 65535, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_RIGHT, 65535, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_RISE, 65535, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_SINK, 65535, 0, 0, 0, 0},
        // opposite flags cancel
        '{FUNC_MOVE, 0, 0, FL_FWD | FL_BACK, 40000, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_RISE | FL_SINK, 40000, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_FWD, 1, 0, 0, 0, 0},
        // move ignores look offsets
        '{FUNC_MOVE, 32767, -32768, FL_ALL, 65535, 0, 0, 0, 0},
        '{FUNC_LOOK, -300, -100, FL_NONE, 0, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_FWD | FL_RIGHT | FL_RISE, 65535, 0, 0, 0, 0},
        '{FUNC_LOOK, 1800, 450, FL_NONE, 0, 0, 0, 0, 0},
        '{FUNC_MOVE, -5, 7, FL_LEFT | FL_BACK | FL_SINK, 12345, 0, 0, 0, 0},
        '{FUNC_MOVE, 0, 0, FL_NONE, 65535, 0, 0, 0, 0}
    };

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // round half up, shift right
    function automatic longint rnd_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint trig_prod(longint a, longint b);
        return rnd_shift(a * b, TRIG_BITS);
    endfunction

    function automatic logic signed [15:0] q14(longint v);
        longint r;
        r = rnd_shift(v, TRIG_BITS - 14);
        return 16'(clamp(r, -16384, 16384));
    endfunction

    // degree CORDIC: fold into +-90, rotate, unfold
    task automatic rotate_angle(input longint ang, output longint s, output longint c);
        longint z, x, y, nx;
        bit     flip;
        z = ang;
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (z > HALF) z -= FULL;
        if (z > QUARTER) begin
            z -= HALF;
            flip = 1'b1;
        end else if (z < -QUARTER) begin
            z += HALF;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_DEG[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_DEG[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp(rnd_shift(x, 30 - TRIG_BITS), -(64'sd1 <<< TRIG_BITS), 64'sd1 <<< TRIG_BITS);
        s = clamp(rnd_shift(y, 30 - TRIG_BITS), -(64'sd1 <<< TRIG_BITS), 64'sd1 <<< TRIG_BITS);
    endtask

    function automatic void nudge(int axis, longint d);
        cam_pos[axis] = clamp(cam_pos[axis] + d, -64'sd2147483648, 64'sd2147483647);
    endfunction

    // advance the camera by one accepted item and return the pose it reports
    task automatic advance_camera(input t_cmd c, output t_pose p);
        longint sy, cy, sp, cp, vel, fx, fz, yaw;
        if (c.func == FUNC_LOOK) begin
            yaw = (cam_yaw + longint'(c.dx) * longint'(cam_sens)) % FULL;
            if (yaw < 0) yaw += FULL;
            cam_yaw = yaw;
            cam_pitch = clamp(cam_pitch + longint'(c.dy) * longint'(cam_sens),
                              -PITCH_LIM, PITCH_LIM);
            rotate_angle(cam_yaw, sy, cy);
        end else begin
            vel = (longint'(cam_speed) * longint'(c.ft)) >>> 16;
            rotate_angle(cam_yaw, sy, cy);
            fx = trig_prod(vel, cy);
            fz = trig_prod(vel, sy);
            if (c.flags & FL_FWD)   begin nudge(0, fx);  nudge(2, fz);  end
            if (c.flags & FL_BACK)  begin nudge(0, -fx); nudge(2, -fz); end
            if (c.flags & FL_LEFT)  begin nudge(0, fz);  nudge(2, -fx); end
            if (c.flags & FL_RIGHT) begin nudge(0, -fz); nudge(2, fx);  end
            if (c.flags & FL_RISE)  nudge(1, vel);
            if (c.flags & FL_SINK)  nudge(1, -vel);
        end
        rotate_angle((cam_pitch < 0) ? cam_pitch + FULL : cam_pitch, sp, cp);
        p.pos_x   = 32'(cam_pos[0]);
        p.pos_y   = 32'(cam_pos[1]);
        p.pos_z   = 32'(cam_pos[2]);
        p.front_x = q14(trig_prod(cy, cp));
        p.front_y = q14(sp);
        p.front_z = q14(trig_prod(sy, cp));
        p.up_x    = q14(-trig_prod(cy, sp));
        p.up_y    = q14(cp);
        p.up_z    = q14(-trig_prod(sy, sp));
    endtask

    // offer one item after a random gap; valid stays high for back-to-back transfers
    task automatic send_item(input t_cmd c, input bit typed, input int px, py, pz);
        int    gap;
        t_pose p;
        gap = tx_gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= c.func;
        in_ch.look_dx    <= c.dx;
        in_ch.look_dy    <= c.dy;
        in_ch.move_fwd   <= c.flags[5];
        in_ch.move_back  <= c.flags[4];
        in_ch.move_left  <= c.flags[3];
        in_ch.move_right <= c.flags[2];
        in_ch.move_rise  <= c.flags[1];
        in_ch.move_sink  <= c.flags[0];
        in_ch.frame_time <= c.ft;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        advance_camera(c, p);
        if (typed) begin
            p.pos_x = px;
            p.pos_y = py;
            p.pos_z = pz;
        end
        pose_q.push_back(p);
        n_items++;
    endtask

    // wait until every result is back, then let the unit settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        // a zero write leaves the register alone
        if (idx == CFG_MOVE_SPEED && val != 0) cam_speed = val;
        if (idx == CFG_LOOK_SENS && val[15:0] != 0) cam_sens = val[15:0];
        n_cfg++;
    endtask

    function automatic logic signed [15:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 31)) - 16'sd16;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cmd pick_item(int mix);
        t_cmd c;
        c.dx    = pick_offset();
        c.dy    = pick_offset();
        c.flags = 6'($urandom);
        c.ft    = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
        if ($urandom_range(0, 15) == 0) c.ft = 16'd0;
        case (mix)
            MIX_CLIMB: begin
                c.func = ($urandom_range(0, 9) != 0) ? FUNC_MOVE : FUNC_LOOK;
                c.flags = (c.flags & (FL_FWD | FL_RIGHT | FL_LEFT)) | FL_RISE;
                c.ft = 16'hffff - 16'($urandom_range(0, 255));
            end
            MIX_DIVE: begin
                c.func = ($urandom_range(0, 9) != 0) ? FUNC_MOVE : FUNC_LOOK;
                c.flags = (c.flags & (FL_BACK | FL_LEFT)) | FL_SINK;
                c.ft = 16'hffff - 16'($urandom_range(0, 255));
            end
            default: c.func = 1'($urandom);
        endcase
        return c;
    endfunction

    task automatic run_random(input int count, input int mix);
        for (int k = 0; k < count; k++) send_item(pick_item(mix), 1'b0, 0, 0, 0);
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // result side: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_pose want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: result with nothing pending", $time);
                fail_cnt++;
            end else begin
                want = pose_q.pop_front();
                compare_field("pos_x", want.pos_x, out_ch.pos_x);
                compare_field("pos_y", want.pos_y, out_ch.pos_y);
                compare_field("pos_z", want.pos_z, out_ch.pos_z);
                compare_field("front_x", want.front_x, out_ch.front_x);
                compare_field("front_y", want.front_y, out_ch.front_y);
                compare_field("front_z", want.front_z, out_ch.front_z);
                compare_field("up_x", want.up_x, out_ch.up_x);
                compare_field("up_y", want.up_y, out_ch.up_y);
                compare_field("up_z", want.up_z, out_ch.up_z);
                n_checked++;
            end
        end
    end

    // guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pose_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure; a hold request stalls it for a long stretch
    initial begin : drive_ready
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_asked != hold_served) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served++;
            end else begin
                stall = rx_stalls_on ? $urandom_range(0, 13) : 0;
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin : stimulus
        t_cmd c;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_LOOK;
        in_ch.look_dx    <= '0;
        in_ch.look_dy    <= '0;
        in_ch.move_fwd   <= 1'b0;
        in_ch.move_back  <= 1'b0;
        in_ch.move_left  <= 1'b0;
        in_ch.move_right <= 1'b0;
        in_ch.move_rise  <= 1'b0;
        in_ch.move_sink  <= 1'b0;
        in_ch.frame_time <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_MOVE_SPEED;
        cfg_ch.data      <= '0;
        cam_yaw   = longint'(YAW_RESET);
        cam_pitch = 0;
        cam_pos   = '{0, 0, 0};
        cam_speed = SPEED_RESET;
        cam_sens  = SENS_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan at reset register values
        foreach (plan[r]) begin
            c.func  = plan[r].func;
            c.dx    = 16'(plan[r].dx);
            c.dy    = 16'(plan[r].dy);
            c.flags = plan[r].flags;
            c.ft    = 16'(plan[r].ft);
            send_item(c, plan[r].typed, plan[r].px, plan[r].py, plan[r].pz);
        end

        // default registers; a long receiver hold fills the unit and stalls input
        run_random(100, MIX_ANY);
        hold_asked++;
        run_random(40, MIX_ANY);

        // sender pauses for a full drain, then a burst with no idling on either side
        drain_results();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        run_random(120, MIX_ANY);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;

        // smallest settings
        write_reg(CFG_MOVE_SPEED, 24'd1);
        write_reg(CFG_LOOK_SENS, 24'd1);
        run_random(150, MIX_ANY);

        // zero writes must be ignored
        write_reg(CFG_MOVE_SPEED, 24'd0);
        write_reg(CFG_LOOK_SENS, 24'd0);
        run_random(60, MIX_ANY);

        // largest settings: drive position into saturation both ways
        write_reg(CFG_MOVE_SPEED, 24'hffffff);
        write_reg(CFG_LOOK_SENS, 24'h00ffff);
        run_random(150, MIX_ANY);
        run_random(260, MIX_CLIMB);
        run_random(360, MIX_DIVE);

        // middle settings, upper data bits set above the sensitivity width
        write_reg(CFG_MOVE_SPEED, 24'd1234567);
        write_reg(CFG_LOOK_SENS, 24'hab8421);
        run_random(200, MIX_ANY);

        // back to the reset values
        write_reg(CFG_MOVE_SPEED, SPEED_RESET);
        write_reg(CFG_LOOK_SENS, 24'(SENS_RESET));
        run_random(150, MIX_ANY);

        drain_results();
        $display("summary: %0d items sent, %0d results checked, %0d register writes",
                 n_items, n_checked, n_cfg);
        $display("summary: pose ended at (%0d, %0d, %0d), yaw %0d, pitch %0d",
                 cam_pos[0], cam_pos[1], cam_pos[2], cam_yaw / DEG_ONE, cam_pitch / DEG_ONE);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/fcpu_pkg.sv
rtl/fcpu_if.sv
rtl/fcpu_cordic.sv
rtl/fly_camera_pose_update_unit.sv
tb/sv/fly_camera_pose_update_unit_test.sv
